FILE: rtl/core/rmse_pkg.sv
// Shared constants, codes and control types of the run merge sort engine.
package rmse_pkg;

  localparam int CAPACITY  = 1024;
  localparam int RUN_LIMIT = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int POS_W     = ADDR_W + 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MINRUN,
    ST_INS_RUN,
    ST_INS_CHK,
    ST_INS_KEY,
    ST_INS_GRAB,
    ST_INS_SHIFT,
    ST_MRG_PASS,
    ST_MRG_PAIR,
    ST_MRG_RD,
    ST_MRG_WR,
    ST_CPY_RD,
    ST_CPY_WR
  } state_t;

  typedef struct packed {
    logic              start;
    logic              opcode;
    logic [DATA_W-1:0] value;
    logic              is_last;
  } rmse_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] sorted_value;
    logic              final_flag;
    status_t           status;
  } rmse_res_t;

endpackage

FILE: rtl/core/rmse_req_if.sv
// Request channel: valid/ready handshake carrying one load or read item.
interface rmse_req_if;
  import rmse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DATA_W-1:0] value;
  logic                     is_last;

  modport source (output valid, output opcode, output value, output is_last, input ready);
  modport sink   (input valid, input opcode, input value, input is_last, output ready);
endinterface

FILE: rtl/core/rmse_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
interface rmse_rsp_if;
  import rmse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_flag;
  logic [1:0]               status;

  modport source (output valid, output sorted_value, output final_flag, output status,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_flag, input status,
                  output ready);
endinterface

FILE: rtl/core/run_merge_sort_engine.sv
// Top level of the run merge sort engine: handshakes, result register and checks.
//
// Usage: values arrive on req as loads (opcode 0), one per transfer, up to 1024
// per batch; a load with is_last set closes the batch and sorts it ascending.
// Reads (opcode 1) then return the values in order on rsp, final_flag marking
// the last one, after which the batch is cleared. Every request gives exactly
// one response: loads report status 1 when the store is full and the value is
// dropped, reads report status 2 when nothing sorted is left.
// A load, and a read with nothing left to return, is answered in the next cycle,
// and a plain load can follow every cycle while rsp is ready; any other read
// first passes through the READ state, which fetches its value from the store.
// Sorting after the closing load keeps req.ready low until it completes, for a
// span set by the single read/compare/write path through the element store: each
// merge step and each copy-back step uses a read state and a write state,
// and each insertion shift one state.
// Reset clears the count, read pointer and sorted flag; store contents are kept.
// A stalled rsp holds its result in the output register; a new request is
// taken only once that register is free or being emptied in the same cycle.
module run_merge_sort_engine
  import rmse_pkg::*;
(
  input logic        clk,
  input logic        rst,
  rmse_req_if.sink   req,
  rmse_rsp_if.source rsp
);

  rmse_cmd_t cmd;
  rmse_res_t res;
  logic      idle;
  logic      accept;

  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic              out_final;
  status_t           out_status;

  assign req.ready = idle && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  always_comb begin
    cmd.start   = accept;
    cmd.opcode  = req.opcode;
    cmd.value   = req.value;
    cmd.is_last = req.is_last;
  end

  rmse_sorter u_sorter (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .idle (idle),
    .res  (res)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_value  <= res.sorted_value;
      out_final  <= res.final_flag;
      out_status <= res.status;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.sorted_value = out_value;
  assign rsp.final_flag   = out_final;
  assign rsp.status       = out_status;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!out_valid || rsp.ready))
    else $error("result produced while output register still holds one");

  a_load_answers: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == OP_LOAD) |=> rsp.valid)
    else $error("load transfer not answered in the next cycle");

  a_read_answers: assert property (@(posedge clk) disable iff (rst)
    (accept && req.opcode == OP_READ) ##1 !rsp.valid |=> rsp.valid)
    else $error("read transfer not answered within two cycles");

  a_final_ok: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.final_flag |-> res.status == STATUS_OK)
    else $error("final element reported with a failing status");

endmodule

FILE: rtl/core/rmse_sorter.sv
// Element store, merge scratch memory and the sequencer that sorts and reads them.
module rmse_sorter
  import rmse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rmse_cmd_t cmd,
  output logic      idle,
  output rmse_res_t res
);

  logic [DATA_W-1:0] store_mem   [CAPACITY];
  logic [DATA_W-1:0] scratch_mem [CAPACITY];

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  read_pointer;
  logic              sorted_ready;
  logic [CNT_W-1:0]  tmp;
  logic              sticky;
  logic [CNT_W-1:0]  run;
  logic [POS_W-1:0]  r0, last, i, j, a, b, k, mid, hi, width;
  logic [DATA_W-1:0] key, rd_a, rd_b, rd_s;

  logic [POS_W-1:0]  n_pos, n_last, run_end, run_last, mid_raw, hi_raw, mid_c, hi_c;
  logic [CNT_W-1:0]  eff_count, load_count, rp_inc;
  logic              store_full, is_load, is_read, read_ok, a_done, b_done, take_a, shift_go;
  logic              read_final;

  logic [ADDR_W-1:0] addr_a, addr_b, store_wa, scr_ra;
  logic              store_we, scr_we;
  logic [DATA_W-1:0] store_wd, scr_wd;
  logic [POS_W-1:0]  j_back;

  // Shared arithmetic and compares
  always_comb begin
    n_pos      = POS_W'(count);
    n_last     = n_pos - POS_W'(1);
    eff_count  = sorted_ready ? '0 : count;
    store_full = (eff_count == CNT_W'(CAPACITY));
    load_count = store_full ? eff_count : eff_count + CNT_W'(1);
    is_load    = cmd.start && (cmd.opcode == OP_LOAD);
    is_read    = cmd.start && (cmd.opcode == OP_READ);
    read_ok    = sorted_ready && (read_pointer < count);
    rp_inc     = read_pointer + CNT_W'(1);
    read_final = (rp_inc == count);
    run_end    = r0 + POS_W'(run);
    run_last   = ((run_end < n_pos) ? run_end : n_pos) - POS_W'(1);
    mid_raw    = i + width - POS_W'(1);
    hi_raw     = i + (width << 1) - POS_W'(1);
    mid_c      = (mid_raw < n_last) ? mid_raw : n_last;
    hi_c       = (hi_raw < n_last) ? hi_raw : n_last;
    a_done     = (a > mid);
    b_done     = (b > hi);
    take_a     = !a_done && (b_done || ($signed(rd_a) <= $signed(rd_b)));
    shift_go   = (j > r0) && ($signed(rd_b) > $signed(key));
    j_back     = j - POS_W'(2);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (is_load && cmd.is_last && (load_count >= CNT_W'(2))) state_next = ST_MINRUN;
        else if (is_read && read_ok) state_next = ST_READ;
      end
      ST_READ:      state_next = ST_IDLE;
      ST_MINRUN:    state_next = (tmp >= CNT_W'(RUN_LIMIT)) ? ST_MINRUN : ST_INS_RUN;
      ST_INS_RUN:   state_next = (r0 >= n_pos) ? ST_MRG_PASS : ST_INS_CHK;
      ST_INS_CHK:   state_next = (i > last) ? ST_INS_RUN : ST_INS_KEY;
      ST_INS_KEY:   state_next = ST_INS_GRAB;
      ST_INS_GRAB:  state_next = ST_INS_SHIFT;
      ST_INS_SHIFT: state_next = shift_go ? ST_INS_SHIFT : ST_INS_CHK;
      ST_MRG_PASS:  state_next = (width >= n_pos) ? ST_IDLE : ST_MRG_PAIR;
      ST_MRG_PAIR:  state_next = (i >= n_pos) ? ST_CPY_RD : ST_MRG_RD;
      ST_MRG_RD:    state_next = ST_MRG_WR;
      ST_MRG_WR:    state_next = (k == hi) ? ST_MRG_PAIR : ST_MRG_RD;
      ST_CPY_RD:    state_next = ST_CPY_WR;
      ST_CPY_WR:    state_next = (k == n_last) ? ST_MRG_PASS : ST_CPY_RD;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Memory ports and result
  always_comb begin
    addr_a   = read_pointer[ADDR_W-1:0];
    addr_b   = '0;
    store_we = 1'b0;
    store_wa = '0;
    store_wd = '0;
    scr_we   = 1'b0;
    scr_wd   = take_a ? rd_a : rd_b;
    scr_ra   = k[ADDR_W-1:0];
    res      = '0;
    res.status = STATUS_OK;
    case (state)
      ST_IDLE: begin
        if (is_load) begin
          store_we   = !store_full;
          store_wa   = eff_count[ADDR_W-1:0];
          store_wd   = cmd.value;
          res.valid  = 1'b1;
          res.status = store_full ? STATUS_FULL : STATUS_OK;
        end else if (is_read && !read_ok) begin
          res.valid  = 1'b1;
          res.status = STATUS_EMPTY;
        end
      end
      ST_READ: begin
        res.valid        = 1'b1;
        res.sorted_value = rd_a;
        res.final_flag   = read_final;
      end
      ST_INS_KEY: begin
        addr_a = i[ADDR_W-1:0];
        addr_b = i[ADDR_W-1:0] - ADDR_W'(1);
      end
      ST_INS_GRAB: addr_b = i[ADDR_W-1:0] - ADDR_W'(1);
      ST_INS_SHIFT: begin
        addr_b   = j_back[ADDR_W-1:0];
        store_we = 1'b1;
        store_wa = j[ADDR_W-1:0];
        store_wd = shift_go ? rd_b : key;
      end
      ST_MRG_RD: begin
        addr_a = a[ADDR_W-1:0];
        addr_b = b[ADDR_W-1:0];
      end
      ST_MRG_WR: scr_we = 1'b1;
      ST_CPY_WR: begin
        store_we = 1'b1;
        store_wa = k[ADDR_W-1:0];
        store_wd = rd_s;
      end
      default: ;
    endcase
    idle = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_wa] <= store_wd;
    rd_a <= store_mem[addr_a];
    rd_b <= store_mem[addr_b];
    if (scr_we) scratch_mem[k[ADDR_W-1:0]] <= scr_wd;
    rd_s <= scratch_mem[scr_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      read_pointer <= '0;
      sorted_ready <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && is_load) begin
        count        <= load_count;
        read_pointer <= '0;
        sorted_ready <= cmd.is_last;
      end else if (state == ST_READ) begin
        if (read_final) begin
          count        <= '0;
          read_pointer <= '0;
          sorted_ready <= 1'b0;
        end else begin
          read_pointer <= rp_inc;
        end
      end
    end
  end

  // Sort datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        tmp    <= load_count;
        sticky <= 1'b0;
      end
      ST_MINRUN: begin
        if (tmp >= CNT_W'(RUN_LIMIT)) begin
          sticky <= sticky | tmp[0];
          tmp    <= tmp >> 1;
        end else begin
          run   <= tmp + CNT_W'(sticky);
          width <= POS_W'(tmp) + POS_W'(sticky);
          r0    <= '0;
        end
      end
      ST_INS_RUN: begin
        last <= run_last;
        i    <= r0 + POS_W'(1);
      end
      ST_INS_CHK: if (i > last) r0 <= r0 + POS_W'(run);
      ST_INS_GRAB: begin
        key <= rd_a;
        j   <= i;
      end
      ST_INS_SHIFT: begin
        if (shift_go) j <= j - POS_W'(1);
        else i <= i + POS_W'(1);
      end
      ST_MRG_PASS: i <= '0;
      ST_MRG_PAIR: begin
        a   <= i;
        b   <= mid_c + POS_W'(1);
        mid <= mid_c;
        hi  <= hi_c;
        k   <= (i >= n_pos) ? '0 : i;
      end
      ST_MRG_WR: begin
        k <= k + POS_W'(1);
        if (take_a) a <= a + POS_W'(1);
        else b <= b + POS_W'(1);
        if (k == hi) i <= i + (width << 1);
      end
      ST_CPY_WR: begin
        k <= k + POS_W'(1);
        if (k == n_last) width <= width << 1;
      end
      default: ;
    endcase
  end

endmodule
